// ===== design/astm_pkg.sv =====
// Shared types and constants of the affine span texture mapper.
package astm_pkg;

  localparam int unsigned ScreenWidthDef    = 320;
  localparam int unsigned TextureSideLog2Def = 6;
  localparam int unsigned LightLevelsDef    = 32;
  localparam int unsigned MaxSpanStepsDef   = 64;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned LightW     = 6;
  localparam int unsigned StepW      = 6;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_LOAD_TEXEL = 2'd0,
    OP_LOAD_SHADE = 2'd1,
    OP_DRAW_SPAN  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_LOW_DETAIL = 2'd0,
    CFG_VIEW_X     = 2'd1,
    CFG_VIEW_Y     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_TEXEL = 2'd0,
    JOB_SHADE = 2'd1,
    JOB_SPAN  = 2'd2
  } job_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [12:0]        load_address;
    logic [7:0]         load_value;
    logic [8:0]         x_start;
    logic [8:0]         x_end;
    logic [7:0]         row;
    logic signed [31:0] u_start;
    logic signed [31:0] v_start;
    logic signed [31:0] u_step;
    logic signed [31:0] v_step;
    logic [4:0]         light_level;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        double_wide;
    logic        last_pixel;
    logic        truncated;
  } out_word_t;

  typedef struct packed {
    job_e              kind;
    logic [12:0]       load_addr;
    logic [7:0]        load_val;
    logic [15:0]       addr;
    logic [StepW-1:0]  last_k;
    logic              cut;
    logic              dw;
    logic [LightW-1:0] light;
    logic [31:0]       u;
    logic [31:0]       v;
    logic [31:0]       du;
    logic [31:0]       dv;
  } job_t;

endpackage

// ===== design/astm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module astm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/astm_front.sv =====
// Front end: accepts input words, decodes them and builds queue jobs.
module astm_front #(
  parameter int unsigned SCREEN_WIDTH   = 320,
  parameter int unsigned LIGHT_LEVELS   = 32,
  parameter int unsigned MAX_SPAN_STEPS = 64
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  astm_pkg::in_word_t in_word_i,
  input  logic               low_detail_i,
  input  logic [8:0]         view_x_i,
  input  logic [7:0]         view_y_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output astm_pkg::job_t     job_o
);
  import astm_pkg::*;

  localparam int unsigned ShadeCount = LIGHT_LEVELS * 256;

  logic        keep;
  logic [8:0]  diff;
  logic [8:0]  row_sum;
  logic [15:0] base;
  logic [9:0]  col0;

  assign diff    = in_word_i.x_end - in_word_i.x_start;
  assign row_sum = {1'b0, in_word_i.row} + {1'b0, view_y_i};
  assign base    = 16'(row_sum) * 16'(SCREEN_WIDTH);
  assign col0    = low_detail_i ? {in_word_i.x_start, 1'b0} : {1'b0, in_word_i.x_start};

  always_comb begin
    job_o           = '0;
    job_o.kind      = JOB_SPAN;
    job_o.load_addr = in_word_i.load_address;
    job_o.load_val  = in_word_i.load_value;
    job_o.addr      = base + 16'(view_x_i) + 16'(col0);
    job_o.dw        = low_detail_i;
    job_o.u         = in_word_i.u_start;
    job_o.v         = in_word_i.v_start;
    job_o.du        = in_word_i.u_step;
    job_o.dv        = in_word_i.v_step;
    job_o.cut       = diff >= 9'(MAX_SPAN_STEPS);
    job_o.last_k    = job_o.cut ? StepW'(MAX_SPAN_STEPS - 1) : StepW'(diff);
    if (7'(in_word_i.light_level) >= 7'(LIGHT_LEVELS)) begin
      job_o.light = LightW'(LIGHT_LEVELS - 1);
    end else begin
      job_o.light = LightW'(in_word_i.light_level);
    end
    keep = 1'b0;
    case (in_word_i.opcode)
      OP_LOAD_TEXEL: begin
        job_o.kind = JOB_TEXEL;
        keep       = 1'b1;
      end
      OP_LOAD_SHADE: begin
        job_o.kind = JOB_SHADE;
        keep       = 15'(in_word_i.load_address) < 15'(ShadeCount);
      end
      OP_DRAW_SPAN: begin
        job_o.kind = JOB_SPAN;
        keep       = in_word_i.x_end >= in_word_i.x_start;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i & keep;

endmodule

// ===== design/astm_queue.sv =====
// Short job queue between the front end and the span engine.
module astm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  astm_pkg::job_t job_i,
  output logic           ready_o,
  output logic           valid_o,
  output astm_pkg::job_t job_o,
  input  logic           pop_i
);
  import astm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o = cnt_q != CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ===== design/astm_back.sv =====
// Span engine: performs loads, walks spans and looks up texels and shades.
module astm_back #(
  parameter int unsigned TEXTURE_SIDE_LOG2 = 6,
  parameter int unsigned LIGHT_LEVELS      = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  astm_pkg::job_t      job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output astm_pkg::out_word_t out_word_o
);
  import astm_pkg::*;

  localparam int unsigned TexAw   = 2 * TEXTURE_SIDE_LOG2;
  localparam int unsigned TexD    = 1 << TexAw;
  localparam int unsigned ShadeD  = LIGHT_LEVELS * 256;
  localparam int unsigned ShadeAw = $clog2(ShadeD);

  typedef struct packed {
    logic [15:0]       addr;
    logic [LightW-1:0] light;
    logic              dw;
    logic              last;
    logic              cut;
  } px_meta_t;

  logic              adv;
  logic              issue;
  logic              busy_q;
  logic [StepW-1:0]  k_q, last_k_q;
  logic [31:0]       u_q, v_q, du_q, dv_q;
  logic [15:0]       addr_q;
  logic [LightW-1:0] light_q;
  logic              dw_q, cut_q;
  logic              s1_valid_q, s2_valid_q, out_valid_q;
  px_meta_t          s1_q, s2_q, s1_d;
  out_word_t         out_q;

  logic              tex_we, shade_we;
  logic [TexAw-1:0]  tex_raddr;
  logic [7:0]        tex_rdata, shade_rdata;
  logic [ShadeAw-1:0] shade_raddr;

  assign adv     = !out_valid_q || out_ready_i;
  assign issue   = adv && busy_q;
  assign q_pop_o = adv && !busy_q && q_valid_i;

  assign tex_we   = q_pop_o && (job_i.kind == JOB_TEXEL);
  assign shade_we = q_pop_o && (job_i.kind == JOB_SHADE);

  assign tex_raddr   = {v_q[FracBits +: TEXTURE_SIDE_LOG2], u_q[FracBits +: TEXTURE_SIDE_LOG2]};
  assign shade_raddr = ShadeAw'({s1_q.light, tex_rdata});

  assign s1_d.addr  = addr_q;
  assign s1_d.light = light_q;
  assign s1_d.dw    = dw_q;
  assign s1_d.last  = k_q == last_k_q;
  assign s1_d.cut   = cut_q;

  astm_ram #(.WIDTH(8), .DEPTH(TexD)) u_texel_ram (
    .clk_i  (clk_i),
    .we_i   (tex_we),
    .waddr_i(TexAw'(job_i.load_addr)),
    .wdata_i(job_i.load_val),
    .re_i   (issue),
    .raddr_i(tex_raddr),
    .rdata_o(tex_rdata)
  );

  astm_ram #(.WIDTH(8), .DEPTH(ShadeD)) u_shade_ram (
    .clk_i  (clk_i),
    .we_i   (shade_we),
    .waddr_i(ShadeAw'(job_i.load_addr)),
    .wdata_i(job_i.load_val),
    .re_i   (adv),
    .raddr_i(shade_raddr),
    .rdata_o(shade_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == last_k_q) begin
          busy_q <= 1'b0;
        end
      end else if (q_valid_i && (job_i.kind == JOB_SPAN)) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      out_q.pixel_address <= s2_q.addr;
      out_q.pixel_color   <= shade_rdata;
      out_q.double_wide   <= s2_q.dw;
      out_q.last_pixel    <= s2_q.last;
      out_q.truncated     <= s2_q.cut;
      if (busy_q) begin
        u_q    <= u_q + du_q;
        v_q    <= v_q + dv_q;
        addr_q <= addr_q + (dw_q ? 16'd2 : 16'd1);
      end else if (q_valid_i) begin
        u_q      <= job_i.u;
        v_q      <= job_i.v;
        du_q     <= job_i.du;
        dv_q     <= job_i.dv;
        addr_q   <= job_i.addr;
        last_k_q <= job_i.last_k;
        light_q  <= job_i.light;
        dw_q     <= job_i.dw;
        cut_q    <= job_i.cut;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q <= last_k_q)
    else $error("span step past its end");

  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && k_q == last_k_q) |=> !busy_q)
    else $error("walker kept running after last step");

  a_pipe_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && adv) |=> out_valid_q)
    else $error("pixel dropped before output register");

endmodule

// ===== design/affine_span_texture_mapper_top.sv =====
// Top level of the affine span texture mapper: config registers, front end, queue, span engine.
//
// Loads are written into their RAMs as they are popped from the queue. A span of n steps (capped at
// MAX_SPAN_STEPS) first starts the walker and then issues one pixel per step, so the rate is
// one pixel per cycle while the output is taken. The pixel walk, one step per cycle while the
// output is taken, runs through the texel RAM read, the shade RAM read and the output register.
// A two-word job queue lets the front end take words while a span is still drawing.
// The RAMs hold no reset state and need no clearing after reset.
module affine_span_texture_mapper_top #(
  parameter int unsigned SCREEN_WIDTH      = astm_pkg::ScreenWidthDef,
  parameter int unsigned TEXTURE_SIDE_LOG2 = astm_pkg::TextureSideLog2Def,
  parameter int unsigned LIGHT_LEVELS      = astm_pkg::LightLevelsDef,
  parameter int unsigned MAX_SPAN_STEPS    = astm_pkg::MaxSpanStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  astm_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output astm_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [8:0]          cfg_data_i
);
  import astm_pkg::*;

  logic       low_q;
  logic [8:0] vx_q;
  logic [7:0] vy_q;
  logic       push, q_ready, q_valid, q_pop;
  job_t       push_job, head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= 1'b0;
      vx_q  <= '0;
      vy_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_DETAIL: low_q <= cfg_data_i[0];
        CFG_VIEW_X:     vx_q  <= cfg_data_i;
        CFG_VIEW_Y:     vy_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  astm_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .LIGHT_LEVELS  (LIGHT_LEVELS),
    .MAX_SPAN_STEPS(MAX_SPAN_STEPS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .low_detail_i(low_q),
    .view_x_i    (vx_q),
    .view_y_i    (vy_q),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .job_o       (push_job)
  );

  astm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .job_o  (head_job),
    .pop_i  (q_pop)
  );

  astm_back #(
    .TEXTURE_SIDE_LOG2(TEXTURE_SIDE_LOG2),
    .LIGHT_LEVELS     (LIGHT_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .job_i      (head_job),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== test/tb_affine_span_texture_mapper_top.sv =====
// Self-checking testbench for the affine span texture mapper: span pixel predictor and drivers.
package span_board_pkg;
  import astm_pkg::*;

  localparam int unsigned SideLog2   = TextureSideLog2Def;
  localparam int unsigned TexelCount = 1 << (2 * SideLog2);
  localparam int unsigned ShadeCount = LightLevelsDef * 256;
  localparam int unsigned ReportMax  = 10;

  class span_pixel_board;
    logic [7:0] texels [TexelCount];
    logic [7:0] shades [ShadeCount];
    logic       low_detail;
    logic [8:0] view_x;
    logic [7:0] view_y;
    out_word_t  expected_pixels [$];
    int unsigned errors;

    function new();
      low_detail = 1'b0;
      view_x     = '0;
      view_y     = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [8:0] data);
      case (idx)
        CFG_LOW_DETAIL: low_detail = data[0];
        CFG_VIEW_X:     view_x = data;
        CFG_VIEW_Y:     view_y = data[7:0];
        default: ;
      endcase
    endfunction

    // Accepted input word: update the stores or queue the pixels of a span.
    function void take_word(in_word_t w);
      int unsigned steps, light, base, col, k;
      logic        cut;
      logic [31:0] u, v;
      logic [7:0]  texel;
      out_word_t   px;
      if (w.opcode == OP_LOAD_TEXEL) begin
        texels[w.load_address % TexelCount] = w.load_value;
      end else if (w.opcode == OP_LOAD_SHADE) begin
        if (w.load_address < ShadeCount) shades[w.load_address] = w.load_value;
      end else if (w.opcode == OP_DRAW_SPAN && w.x_end >= w.x_start) begin
        light = (w.light_level < LightLevelsDef) ? w.light_level : LightLevelsDef - 1;
        steps = w.x_end - w.x_start + 1;
        cut   = (steps > MaxSpanStepsDef);
        if (cut) steps = MaxSpanStepsDef;
        base = (w.row + view_y) * ScreenWidthDef + view_x;
        u = w.u_start;
        v = w.v_start;
        for (k = 0; k < steps; k++) begin
          col   = low_detail ? 2 * (w.x_start + k) : w.x_start + k;
          texel = texels[{v[FracBits +: SideLog2], u[FracBits +: SideLog2]}];
          px.pixel_address = 16'(base + col);
          px.pixel_color   = shades[light * 256 + texel];
          px.double_wide   = low_detail;
          px.last_pixel    = (k + 1 == steps);
          px.truncated     = cut;
          expected_pixels.push_back(px);
          u += w.u_step;
          v += w.v_step;
        end
      end
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("unexpected pixel: addr %0d color %0d", got.pixel_address, got.pixel_color);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_address !== want.pixel_address || got.pixel_color !== want.pixel_color ||
          got.double_wide !== want.double_wide || got.last_pixel !== want.last_pixel ||
          got.truncated !== want.truncated) begin
        errors++;
        if (errors <= ReportMax)
          $display("pixel mismatch (exp/got): addr %0d/%0d color %0d/%0d wide %0b/%0b",
                   want.pixel_address, got.pixel_address, want.pixel_color, got.pixel_color,
                   want.double_wide, got.double_wide, " last %0b/%0b cut %0b/%0b",
                   want.last_pixel, got.last_pixel, want.truncated, got.truncated);
      end
    endfunction
  endclass
endpackage

module tb_affine_span_texture_mapper_top;
  timeunit 1ns;
  timeprecision 1ps;
  import astm_pkg::*;
  import span_board_pkg::*;

  localparam logic [1:0]  OpUnused     = 2'd3;
  localparam int unsigned SettleCycles = 20;
  localparam logic [5:0]  TexRow       = 6'd41;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i  = '0;

  span_pixel_board board;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  affine_span_texture_mapper_top dut (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Output side: check each taken word, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_pixel(out_word_o);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= (stall_left % 3 == 0);
        default: out_ready_i <= ($urandom_range(0, 19) == 0);
      endcase
    end
  end

  function automatic in_word_t random_fields();
    in_word_t w;
    w.opcode       = 2'($urandom_range(0, 3));
    w.load_address = 13'($urandom_range(0, 8191));
    w.load_value   = 8'($urandom_range(0, 255));
    w.x_start      = 9'($urandom_range(0, 319));
    w.x_end        = 9'($urandom_range(0, 319));
    w.row          = 8'($urandom_range(0, 199));
    w.u_start      = $urandom;
    w.v_start      = $urandom;
    w.u_step       = $urandom;
    w.v_step       = $urandom;
    w.light_level  = 5'($urandom_range(0, 31));
    return w;
  endfunction

  // Spans only reach texel row TexRow, texel values from this set and these lights.
  function automatic logic [7:0] texel_pick(input int unsigned i);
    case (i % 4)
      0: return 8'h00;
      1: return 8'h5A;
      2: return 8'hA5;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [4:0] light_pick(input int unsigned i);
    case (i % 4)
      0: return 5'd0;
      1: return 5'd5;
      2: return 5'd17;
      default: return 5'd31;
    endcase
  endfunction

  function automatic in_word_t fit_span(input in_word_t w);
    w.v_start[21:16] = TexRow;
    w.v_step[21:0]   = '0;
    return w;
  endfunction

  function automatic in_word_t load_word(input opcode_e op, input logic [12:0] addr,
                                         input logic [7:0] val);
    in_word_t w;
    w = random_fields();
    w.opcode       = op;
    w.load_address = addr;
    w.load_value   = val;
    return w;
  endfunction

  function automatic in_word_t span_word(input logic [8:0] x0, input logic [8:0] x1,
                                         input logic [7:0] row, input logic [31:0] u,
                                         input logic [31:0] v, input logic [31:0] du,
                                         input logic [31:0] dv, input logic [4:0] light);
    in_word_t w;
    w = random_fields();
    w.opcode      = OP_DRAW_SPAN;
    w.x_start     = x0;
    w.x_end       = x1;
    w.row         = row;
    w.u_start     = u;
    w.v_start     = v;
    w.u_step      = du;
    w.v_step      = dv;
    w.light_level = light;
    return fit_span(w);
  endfunction

  function automatic in_word_t shape_span(input in_word_t w);
    int unsigned len;
    w.opcode = OP_DRAW_SPAN;
    case ($urandom_range(0, 9))
      0: begin
        w.x_start = 9'($urandom_range(1, 319));
        w.x_end   = 9'($urandom_range(0, w.x_start - 1));
      end
      1: begin
        w.x_start = 9'($urandom_range(0, 250));
        w.x_end   = 9'($urandom_range(w.x_start + 64, 319));
      end
      default: begin
        len       = $urandom_range(1, 24);
        w.x_start = 9'($urandom_range(0, 320 - len));
        w.x_end   = 9'(w.x_start + len - 1);
      end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      w.u_step = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      w.v_step = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    end
    w.light_level = light_pick($urandom_range(0, 3));
    return fit_span(w);
  endfunction

  task automatic push_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic low, input logic [8:0] vx, input logic [7:0] vy);
    write_reg(CFG_LOW_DETAIL, {8'd0, low});
    write_reg(CFG_VIEW_X, vx);
    write_reg(CFG_VIEW_Y, {1'b0, vy});
  endtask

  task automatic run_random(input int unsigned count);
    in_word_t w;
    int unsigned taken;
    taken = 0;
    while (taken < count) begin
      w = random_fields();
      case ($urandom_range(0, 19))
        12, 13, 14: begin
          w.opcode     = OP_LOAD_TEXEL;
          w.load_value = texel_pick($urandom_range(0, 3));
        end
        15, 16, 17: w.opcode = OP_LOAD_SHADE;
        18:         w.opcode = OpUnused;
        default:    w = shape_span(w);
      endcase
      push_word(w);
      if (w.opcode != OpUnused) taken++;
    end
  endtask

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_word_t w;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure(1'b0, 9'd0, 8'd0);

    // fill the texel row and the shade entries that spans can reach
    for (int i = 0; i < (1 << SideLog2); i++)
      push_word(load_word(OP_LOAD_TEXEL, {1'($urandom_range(0, 1)), TexRow, 6'(i)},
                          texel_pick($urandom_range(0, 3))));
    for (int l = 0; l < 4; l++)
      for (int t = 0; t < 4; t++)
        push_word(load_word(OP_LOAD_SHADE, {light_pick(l), texel_pick(t)},
                            8'($urandom_range(0, 255))));

    push_word(load_word(OP_LOAD_TEXEL, 13'h1FFF, 8'hFF));
    push_word(load_word(OP_LOAD_SHADE, 13'h1FFF, 8'hA5));
    push_word(load_word(OP_LOAD_TEXEL, 13'h0000, 8'hFF));
    push_word(span_word(0, 0, 0, 0, 0, 0, 0, 31));
    push_word(span_word(319, 319, 199, 32'h003F_0000, 32'h003F_0000, 0, 0, 31));
    push_word(span_word(0, 63, 100, 0, 0, 32'h0001_0000, 32'h0040_0000, 0));
    push_word(span_word(0, 64, 37, 32'h0020_8000, 32'hFFFF_0000, 32'h0000_C000,
                        32'h00C0_0000, 5));
    push_word(span_word(0, 319, 150, 32'h7FFF_8000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 17));
    push_word(span_word(319, 0, 10, 0, 0, 32'h0001_0000, 0, 5));
    push_word(span_word(1, 0, 10, 0, 0, 0, 32'h0001_0000, 5));
    w = random_fields();
    w.opcode = OpUnused;
    push_word(w);
    push_word(span_word(256, 319, 128, 32'hFFFF_FFFF, 32'h0010_0000, 32'hFFFF_0000,
                        32'hFFC0_0000, 17));
    push_word(load_word(OP_LOAD_TEXEL, 13'h1A40, 8'h00));
    push_word(load_word(OP_LOAD_SHADE, 13'h0000, 8'h00));
    push_word(span_word(0, 0, 0, 0, 0, 0, 0, 0));
    push_word(span_word(10, 20, 199, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFC0_0000, 31));
    drain();

    configure(1'b1, 9'd319, 8'd199);
    run_random(21);
    drain();
    configure(1'b0, 9'($urandom_range(192, 255)), 8'($urandom_range(56, 63)));
    run_random(21);
    drain();
    configure(1'b1, 9'd0, 8'd0);
    run_random(21);
    drain();
    configure(1'b0, 9'd319, 8'd199);
    run_random(21);
    drain();

    if (board.errors == 0 && board.expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
